// ===== hdl/ray_oriented_box_slab_test_core_assert.svh =====
// ----------------------------------------------------------------------------
// ray_oriented_box_slab_test_core_assert
// assertion macros shared by the slab test core
// ----------------------------------------------------------------------------
`ifndef RAY_ORIENTED_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_ORIENTED_BOX_SLAB_TEST_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define ROBST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// implication checked on the following edge
`define ROBST_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hdl/robst_pkg.sv =====
// ----------------------------------------------------------------------------
// robst_pkg
// constants and register indexes of the oriented box slab test
// ----------------------------------------------------------------------------
package robst_pkg;

	// default coordinate width, signed Q16.8
	localparam int COORD_WIDTH_DEF = 24;
	// direction and axis components, signed Q2.14
	localparam int DIR_W = 16;
	localparam int AXIS_W = 48;
	localparam int FRAC_SHIFT = 14;
	// 0.001 in Q.28
	localparam int PAR_LIMIT = 268435;
	// 100000.0 in Q.8
	localparam int T_FAR_Q8 = 25600000;
	localparam int DIST_W = 25;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = AXIS_W;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_HALF_WIDTH = 3'd3,
		REG_AXIS_X = 3'd4,
		REG_AXIS_Y = 3'd5,
		REG_AXIS_Z = 3'd6
	} cfg_reg_t;

endpackage

// ===== hdl/ray_oriented_box_slab_test_core.sv =====
// ----------------------------------------------------------------------------
// ray_oriented_box_slab_test_core
// ray versus oriented cube test, slab method, fully pipelined
// ----------------------------------------------------------------------------
// Usage:
// A ray enters on the s_axis stream, one transfer per ray; tdata holds
// origin x/y/z and direction x/y/z. One result leaves on m_axis per ray,
// in order: hit flag and near distance tmin (zero on a miss).
// The cube is set through the cfg write channel (index, data), which is
// always ready; write it only while no ray is in flight.
// Throughput is one ray per cycle while the receiver does not stall. The
// pipeline depth is set by the restoring dividers, which retire one quotient
// bit per stage over a dividend of COORD_WIDTH + 34 bits, six lanes in parallel.
// Reset loads the default cube (half width 1.0 at the origin, world axes) and
// empties the pipeline. When the receiver stalls, the result is held in
// the output register and the stages behind it keep filling empty slots;
// input is refused only once every stage holds a ray.
// ----------------------------------------------------------------------------
`include "ray_oriented_box_slab_test_core_assert.svh"

module ray_oriented_box_slab_test_core #(
	parameter int COORD_WIDTH = robst_pkg::COORD_WIDTH_DEF,
	localparam int IN_W = ((3 * COORD_WIDTH + 3 * robst_pkg::DIR_W + 7) / 8) * 8,
	localparam int OUT_W = ((1 + robst_pkg::DIST_W + 7) / 8) * 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [robst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [robst_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first), zero pad
	input  logic [IN_W-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// hit, distance (lowest first), zero pad
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int CW = COORD_WIDTH;
	localparam int DRW = robst_pkg::DIR_W;
	localparam int DW = CW + 1;
	localparam int PW = DW + DRW;
	localparam int EW = PW + 2;
	localparam int NW = EW + 1;
	localparam int FS = 2 * DRW + 2;
	localparam int FM = FS;
	localparam int QW = NW + robst_pkg::FRAC_SHIFT;
	localparam int TW = QW + 1;
	localparam int DSW = robst_pkg::DIST_W;
	// stage map: s1, s2, s3, divider 0..QW, s5..s9
	localparam int DV0 = 3;
	localparam int S5 = DV0 + QW + 1;
	localparam int NSTG = S5 + 5;
	localparam logic signed [TW-1:0] TFAR = TW'(robst_pkg::T_FAR_Q8);
	localparam logic [FM-1:0] PLIM = FM'(robst_pkg::PAR_LIMIT);

	// configuration registers
	logic signed [CW-1:0] ctr_q [3];
	logic [CW-2:0] hw_q;
	logic [robst_pkg::AXIS_W-1:0] axis_q [3];

	// valid bits and stage enables
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	// stage payloads
	logic signed [DW-1:0] d_s1 [3];
	logic signed [DRW-1:0] dir_s1 [3];
	logic signed [PW-1:0] cd_s2 [3][3];
	logic signed [2*DRW-1:0] cf_s2 [3][3];
	logic signed [EW-1:0] e_s3 [3];
	logic signed [FS-1:0] f_s3 [3];
	logic [QW-1:0] dq_s [QW+1][6];
	logic [FM-1:0] dr_s [QW+1][6];
	logic [5:0] dneg_s [QW+1];
	logic [FM-1:0] dfm_s [QW+1][3];
	logic [2:0] dpar_s [QW+1];
	logic dout_s [QW+1];
	logic signed [TW-1:0] t_s5 [6];
	logic [2:0] par_s5;
	logic out_s5;
	logic signed [TW-1:0] t1_s6 [3];
	logic signed [TW-1:0] t2_s6 [3];
	logic out_s6;
	logic signed [TW-1:0] mn01_s7, mn2_s7, mx01_s7, mx2_s7;
	logic out_s7;
	logic signed [TW-1:0] tmin_s8, tmax_s8;
	logic out_s8;
	logic hit_s9;
	logic [DSW-1:0] dist_s9;

	// axis component k of box axis a
	function automatic logic signed [DRW-1:0] comp(input logic [robst_pkg::AXIS_W-1:0] ax,
		input int k);
		return $signed(ax[DRW*k +: DRW]);
	endfunction

	// configuration writes
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q[0] <= '0;
			ctr_q[1] <= '0;
			ctr_q[2] <= '0;
			hw_q <= (CW-1)'(256);
			axis_q[0] <= robst_pkg::AXIS_W'(64'd16384);
			axis_q[1] <= robst_pkg::AXIS_W'(64'd16384 << 16);
			axis_q[2] <= robst_pkg::AXIS_W'(64'd16384 << 32);
		end else if (cfg_valid && cfg_ready) begin
			case (robst_pkg::cfg_reg_t'(cfg_index))
				robst_pkg::REG_CENTER_X: ctr_q[0] <= cfg_data[CW-1:0];
				robst_pkg::REG_CENTER_Y: ctr_q[1] <= cfg_data[CW-1:0];
				robst_pkg::REG_CENTER_Z: ctr_q[2] <= cfg_data[CW-1:0];
				robst_pkg::REG_HALF_WIDTH: hw_q <= cfg_data[CW-2:0];
				robst_pkg::REG_AXIS_X: axis_q[0] <= cfg_data;
				robst_pkg::REG_AXIS_Y: axis_q[1] <= cfg_data;
				robst_pkg::REG_AXIS_Z: axis_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the stage after it moves
	always_comb begin
		en[NSTG-1] = !vld_q[NSTG-1] || m_axis_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end
	assign s_axis_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) vld_q[0] <= s_axis_tvalid;
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// s1: center minus origin
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= DW'(ctr_q[k]) - DW'($signed(s_axis_tdata[CW*k +: CW]));
				dir_s1[k] <= $signed(s_axis_tdata[3*CW + DRW*k +: DRW]);
			end
		end
	end

	// s2: component products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					cd_s2[a][k] <= PW'(comp(axis_q[a], k)) * PW'(d_s1[k]);
					cf_s2[a][k] <= (2*DRW)'(comp(axis_q[a], k)) * (2*DRW)'(dir_s1[k]);
				end
			end
		end
	end

	// s3: dot products e and f per axis
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int a = 0; a < 3; a++) begin
				e_s3[a] <= EW'(cd_s2[a][0]) + EW'(cd_s2[a][1]) + EW'(cd_s2[a][2]);
				f_s3[a] <= FS'(cf_s2[a][0]) + FS'(cf_s2[a][1]) + FS'(cf_s2[a][2]);
			end
		end
	end

	// divider entry: slab numerators as magnitude and sign, parallel and outside tests
	always_ff @(posedge clk) begin : dv_entry
		logic signed [NW-1:0] hs;
		logic signed [NW-1:0] num;
		logic [NW-1:0] mag;
		logic anyout;
		if (en[DV0]) begin
			hs = NW'($signed({1'b0, hw_q, {robst_pkg::FRAC_SHIFT{1'b0}}}));
			anyout = 1'b0;
			for (int a = 0; a < 3; a++) begin
				dfm_s[0][a] <= f_s3[a][FS-1] ? FM'(-f_s3[a]) : FM'(f_s3[a]);
				dpar_s[0][a] <= (f_s3[a][FS-1] ? FM'(-f_s3[a]) : FM'(f_s3[a])) <= PLIM;
				if (((f_s3[a][FS-1] ? FM'(-f_s3[a]) : FM'(f_s3[a])) <= PLIM) &&
					((NW'(e_s3[a]) > hs) || (NW'(e_s3[a]) < -hs))) begin
					anyout = 1'b1;
				end
				for (int s = 0; s < 2; s++) begin
					num = (s == 0) ? NW'(e_s3[a]) - hs : NW'(e_s3[a]) + hs;
					mag = num[NW-1] ? NW'(-num) : NW'(num);
					dq_s[0][2*a+s] <= {mag, {robst_pkg::FRAC_SHIFT{1'b0}}};
					dr_s[0][2*a+s] <= '0;
					dneg_s[0][2*a+s] <= num[NW-1] ^ f_s3[a][FS-1];
				end
			end
			dout_s[0] <= anyout;
		end
	end

	// restoring divider, one quotient bit per stage in every lane
	for (genvar g = 1; g <= QW; g++) begin : g_div
		always_ff @(posedge clk) begin : step
			logic [FM:0] tmp;
			logic ge;
			if (en[DV0+g]) begin
				for (int l = 0; l < 6; l++) begin
					tmp = {dr_s[g-1][l], dq_s[g-1][l][QW-1]};
					ge = tmp >= {1'b0, dfm_s[g-1][l/2]};
					dr_s[g][l] <= ge ? FM'(tmp - {1'b0, dfm_s[g-1][l/2]}) : FM'(tmp);
					dq_s[g][l] <= {dq_s[g-1][l][QW-2:0], ge};
				end
				dneg_s[g] <= dneg_s[g-1];
				dfm_s[g] <= dfm_s[g-1];
				dpar_s[g] <= dpar_s[g-1];
				dout_s[g] <= dout_s[g-1];
			end
		end
	end

	// s5: signed quotient rounded toward minus infinity
	always_ff @(posedge clk) begin
		if (en[S5]) begin
			for (int l = 0; l < 6; l++) begin
				if (!dneg_s[QW][l]) begin
					t_s5[l] <= $signed({1'b0, dq_s[QW][l]});
				end else if (dr_s[QW][l] != '0) begin
					t_s5[l] <= ~$signed({1'b0, dq_s[QW][l]});
				end else begin
					t_s5[l] <= -$signed({1'b0, dq_s[QW][l]});
				end
			end
			par_s5 <= dpar_s[QW];
			out_s5 <= dout_s[QW];
		end
	end

	// s6: order the two bounds; a parallel axis leaves them neutral
	always_ff @(posedge clk) begin
		if (en[S5+1]) begin
			for (int a = 0; a < 3; a++) begin
				if (par_s5[a]) begin
					t1_s6[a] <= '0;
					t2_s6[a] <= TFAR;
				end else if (t_s5[2*a] > t_s5[2*a+1]) begin
					t1_s6[a] <= t_s5[2*a+1];
					t2_s6[a] <= t_s5[2*a];
				end else begin
					t1_s6[a] <= t_s5[2*a];
					t2_s6[a] <= t_s5[2*a+1];
				end
			end
			out_s6 <= out_s5;
		end
	end

	// s7: first level of near max and far min
	always_ff @(posedge clk) begin
		if (en[S5+2]) begin
			mn01_s7 <= (t1_s6[0] > t1_s6[1]) ? t1_s6[0] : t1_s6[1];
			mn2_s7 <= (t1_s6[2] > 0) ? t1_s6[2] : '0;
			mx01_s7 <= (t2_s6[0] < t2_s6[1]) ? t2_s6[0] : t2_s6[1];
			mx2_s7 <= (t2_s6[2] < TFAR) ? t2_s6[2] : TFAR;
			out_s7 <= out_s6;
		end
	end

	// s8: final near and far bounds
	always_ff @(posedge clk) begin
		if (en[S5+3]) begin
			tmin_s8 <= (mn01_s7 > mn2_s7) ? mn01_s7 : mn2_s7;
			tmax_s8 <= (mx01_s7 < mx2_s7) ? mx01_s7 : mx2_s7;
			out_s8 <= out_s7;
		end
	end

	// s9: output register
	always_ff @(posedge clk) begin
		if (en[S5+4]) begin
			hit_s9 <= !out_s8 && (tmax_s8 >= tmin_s8);
			dist_s9 <= (!out_s8 && (tmax_s8 >= tmin_s8)) ? tmin_s8[DSW-1:0] : '0;
		end
	end

	assign m_axis_tvalid = vld_q[NSTG-1];
	assign m_axis_tdata = OUT_W'({dist_s9, hit_s9});

	// checks
	`ROBST_ASSERT(a_miss_zero, (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[DSW:1] == '0), "miss with nonzero distance")
	`ROBST_ASSERT(a_hit_range, (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[DSW:1] <= DSW'(robst_pkg::T_FAR_Q8)), "hit distance beyond far bound")
	`ROBST_ASSERT(a_full_stall, !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready), "input refused with output moving")
	`ROBST_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted ray not in first stage")

endmodule

// ===== test/ray_oriented_box_slab_test_core_tb.sv =====
// ----------------------------------------------------------------------------
// ray_oriented_box_slab_test_core_tb
// checks the ray versus oriented cube slab test against its own predictor
// ----------------------------------------------------------------------------
// Rays go in on the input stream; for each accepted ray the expected hit flag
// and near distance are computed from a local copy of the cube settings and
// queued. Every output transfer is compared with the oldest queued result.
// The cube is rewritten between phases, only once the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ray_oriented_box_slab_test_core_tb;

	localparam int CW = robst_pkg::COORD_WIDTH_DEF;
	localparam int DRW = robst_pkg::DIR_W;
	localparam int DSW = robst_pkg::DIST_W;
	localparam int AW = robst_pkg::AXIS_W;
	localparam int DATA_W = robst_pkg::CFG_DATA_W;
	localparam int IN_W = 120;
	localparam int OUT_W = 32;
	localparam int LATENCY = CW + 43;
	localparam int STALL_LIMIT = 3000;
	localparam int ITEMS_PER_BOX = 90;

	typedef struct packed {
		logic [DRW-1:0] dz;
		logic [DRW-1:0] dy;
		logic [DRW-1:0] dx;
		logic [CW-1:0] oz;
		logic [CW-1:0] oy;
		logic [CW-1:0] ox;
	} ray_t;

	typedef struct {
		logic hit;
		logic [DSW-1:0] near_dist;
	} slab_result_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [robst_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
	logic [IN_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	// hit, distance, zero pad
	logic [OUT_W-1:0] m_axis_tdata;

	// local copy of the cube settings
	logic [CW-1:0] box_cx, box_cy, box_cz;
	logic [CW-2:0] box_hw;
	logic [AW-1:0] box_axis [3];

	slab_result_t pending_results [$];
	int err_count;
	int rays_sent;
	int results_seen;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_req;
	int quiet_cycles;

	ray_oriented_box_slab_test_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor division, both signs
	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	// floor(num * 2^14 / f) without overflow
	function automatic longint slab_bound(longint num, longint f);
		longint q, r;
		q = floor_div(num, f);
		r = num - q * f;
		return q * 16384 + floor_div(r * 16384, f);
	endfunction

	function automatic slab_result_t predict_slab(ray_t r);
		slab_result_t res;
		longint d [3];
		longint dv [3];
		longint e, f, c, h, t1, t2, tmp, tmin, tmax;
		bit hit;
		d[0] = longint'($signed(box_cx)) - longint'($signed(r.ox));
		d[1] = longint'($signed(box_cy)) - longint'($signed(r.oy));
		d[2] = longint'($signed(box_cz)) - longint'($signed(r.oz));
		dv[0] = longint'($signed(r.dx));
		dv[1] = longint'($signed(r.dy));
		dv[2] = longint'($signed(r.dz));
		h = longint'(box_hw) * 16384;
		tmin = 0;
		tmax = robst_pkg::T_FAR_Q8;
		hit = 1'b1;
		for (int a = 0; a < 3 && hit; a++) begin
			e = 0;
			f = 0;
			for (int k = 0; k < 3; k++) begin
				c = longint'($signed(box_axis[a][16*k +: 16]));
				e += c * d[k];
				f += c * dv[k];
			end
			if (f > robst_pkg::PAR_LIMIT || f < -robst_pkg::PAR_LIMIT) begin
				t1 = slab_bound(e - h, f);
				t2 = slab_bound(e + h, f);
				if (t1 > t2) begin
					tmp = t1;
					t1 = t2;
					t2 = tmp;
				end
				if (t2 < tmax) tmax = t2;
				if (t1 > tmin) tmin = t1;
				if (tmax < tmin) hit = 1'b0;
			end else if (e < -h || e > h) begin
				hit = 1'b0;
			end
		end
		res.hit = hit;
		res.near_dist = hit ? tmin[DSW-1:0] : '0;
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	// one ray transfer; valid stays high into the next call
	task automatic send_ray(input ray_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= r;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(predict_slab(r));
		rays_sent++;
	endtask

	task automatic wait_empty();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(input robst_pkg::cfg_reg_t idx, input logic [DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			robst_pkg::REG_CENTER_X: box_cx = val[CW-1:0];
			robst_pkg::REG_CENTER_Y: box_cy = val[CW-1:0];
			robst_pkg::REG_CENTER_Z: box_cz = val[CW-1:0];
			robst_pkg::REG_HALF_WIDTH: box_hw = val[CW-2:0];
			robst_pkg::REG_AXIS_X: box_axis[0] = val;
			robst_pkg::REG_AXIS_Y: box_axis[1] = val;
			robst_pkg::REG_AXIS_Z: box_axis[2] = val;
			default: ;
		endcase
	endtask

	// center writes carry junk above the field width
	task automatic set_box(input logic [CW-1:0] cx, input logic [CW-1:0] cy,
			input logic [CW-1:0] cz, input logic [CW-2:0] hw,
			input logic [AW-1:0] ax, input logic [AW-1:0] ay,
			input logic [AW-1:0] az);
		wait_empty();
		write_reg(robst_pkg::REG_CENTER_X, DATA_W'({$urandom, $urandom} << CW | cx));
		write_reg(robst_pkg::REG_CENTER_Y, DATA_W'({$urandom, $urandom} << CW | cy));
		write_reg(robst_pkg::REG_CENTER_Z, DATA_W'({$urandom, $urandom} << CW | cz));
		write_reg(robst_pkg::REG_HALF_WIDTH,
			DATA_W'({$urandom, $urandom} << (CW - 1) | hw));
		write_reg(robst_pkg::REG_AXIS_X, ax);
		write_reg(robst_pkg::REG_AXIS_Y, ay);
		write_reg(robst_pkg::REG_AXIS_Z, az);
	endtask

	function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
		ray_t r;
		r.ox = ox[CW-1:0];
		r.oy = oy[CW-1:0];
		r.oz = oz[CW-1:0];
		r.dx = dx[DRW-1:0];
		r.dy = dy[DRW-1:0];
		r.dz = dz[DRW-1:0];
		return r;
	endfunction

	function automatic ray_t noise_ray();
		logic [127:0] raw;
		ray_t r;
		raw = {$urandom, $urandom, $urandom, $urandom};
		r = raw[IN_W-1:0];
		return r;
	endfunction

	// origin near the cube, direction roughly back toward its center
	function automatic ray_t aimed_ray();
		longint span, m;
		longint off [3];
		longint dv [3];
		span = longint'(box_hw) * 3 + 256;
		if (span > (1 << 20)) span = 1 << 20;
		m = 1;
		for (int k = 0; k < 3; k++) begin
			off[k] = longint'($urandom_range(32'(2 * span))) - span;
			if (off[k] > m) m = off[k];
			if (-off[k] > m) m = -off[k];
		end
		for (int k = 0; k < 3; k++)
			dv[k] = -off[k] * 16384 / m + longint'($urandom_range(4000)) - 2000;
		return make_ray(int'(longint'($signed(box_cx)) + off[0]),
			int'(longint'($signed(box_cy)) + off[1]),
			int'(longint'($signed(box_cz)) + off[2]),
			int'(dv[0]), int'(dv[1]), int'(dv[2]));
	endfunction

	// receiver: random stalls, or a long hold when asked
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left <= 400;
			m_axis_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		slab_result_t exp_res;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with nothing expected");
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata[0] !== exp_res.hit)
					report_mismatch($sformatf("hit %b, expected %b",
						m_axis_tdata[0], exp_res.hit));
				if (m_axis_tdata[DSW:1] !== exp_res.near_dist)
					report_mismatch($sformatf("distance %0d, expected %0d",
						m_axis_tdata[DSW:1], exp_res.near_dist));
				if (m_axis_tdata[OUT_W-1:DSW+1] !== '0)
					report_mismatch("nonzero pad bits in result");
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("ray_oriented_box_slab_test_core_tb: FAIL");
			$finish;
		end
	end

	// corner rays against the default cube of half width 1.0
	task automatic test_directed();
		send_ray(make_ray(-1280, 0, 0, 16384, 0, 0));
		send_ray(make_ray(1280, 0, 0, -16384, 0, 0));
		send_ray(make_ray(0, 0, 0, 1234, -5678, 9000));
		send_ray(make_ray(0, 0, 0, 0, 0, 0));
		send_ray(make_ray(-1280, 0, 0, 0, 0, 0));
		send_ray(make_ray(-1280, 0, 0, 1, 0, 0));
		send_ray(make_ray(-1280, 128, 0, 16384, 0, 0));
		send_ray(make_ray(-1280, 512, 0, 16384, 0, 0));
		send_ray(make_ray(-1280, 0, 0, -16384, 0, 0));
		send_ray(make_ray(-512, -512, 0, 16384, 16384, 0));
		send_ray(make_ray(-512, -1024, 0, 16384, 16384, 0));
		send_ray(make_ray(0, 0, -2560, 0, 0, 32767));
		send_ray(make_ray(8388607, 8388607, 8388607, -32768, -32768, -32768));
		send_ray(make_ray(-8388608, -8388608, -8388608, 32767, 32767, 32767));
		send_ray(make_ray(8388607, -8388608, 0, -32768, 32767, 0));
		send_ray(make_ray(-8388608, 0, 0, 32767, 0, 0));
		send_ray(make_ray(0, 0, 0, -32768, -32768, -32768));
		wait_empty();
	endtask

	// a run of rays against one cube, mostly aimed, some noise
	task automatic run_rays(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 75)
				send_ray(aimed_ray());
			else
				send_ray(noise_ray());
		end
	endtask

	// a spread of cube settings including the field extremes
	task automatic test_box_sweep();
		set_box(24'd0, 24'd0, 24'd0, 23'd256, 48'h0000_0000_4000, 48'h0000_4000_0000,
			48'h4000_0000_0000);
		run_rays(ITEMS_PER_BOX);
		set_box(24'd2560, -24'sd1280, 24'd640, 23'd384,
			48'h0000_2D41_2D41, 48'h0000_D2BF_2D41, 48'h4000_0000_0000);
		run_rays(ITEMS_PER_BOX);
		set_box(24'($urandom), 24'($urandom), 24'($urandom), 23'($urandom_range(4096)),
			48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
			48'({$urandom, $urandom}));
		run_rays(ITEMS_PER_BOX);
		set_box(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'h7FFFFF,
			48'hFFFF_FFFF_FFFF, 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000);
		run_rays(ITEMS_PER_BOX);
		set_box(24'h800000, 24'h800000, 24'h800000, 23'd0,
			48'h0, 48'h0000_4000_0000, 48'h0000_0000_C000);
		run_rays(ITEMS_PER_BOX);
		set_box(24'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
			48'h0000_0000_4000, 48'h0000_4000_0000, 48'h4000_0000_0000);
		run_rays(ITEMS_PER_BOX);
	endtask

	// receiver holds off while the sender keeps offering rays
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_rays(200);
		wait_empty();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		m_axis_tready <= 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		err_count = 0;
		rays_sent = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		box_cx = '0;
		box_cy = '0;
		box_cz = '0;
		box_hw = 23'd256;
		box_axis[0] = 48'h0000_0000_4000;
		box_axis[1] = 48'h0000_4000_0000;
		box_axis[2] = 48'h4000_0000_0000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 13;
		recv_idle_pct = 64;
		test_directed();
		test_box_sweep();
		send_idle_pct = 64;
		recv_idle_pct = 13;
		test_box_sweep();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_box_sweep();
		test_backpressure();

		$display("covered %0d rays and %0d results over directed, swept-cube,",
			rays_sent, results_seen);
		$display("stall-mix and full-pipeline backpressure phases, %0d errors", err_count);
		if (err_count == 0) begin
			$display("ray_oriented_box_slab_test_core_tb: PASS");
		end else begin
			$display("ray_oriented_box_slab_test_core_tb: FAIL");
		end
		$finish;
	end

endmodule
